>>> rtl/core/doeq_pkg.sv
// ----------------------------------------------------------------------------
// doeq_pkg: shared types and constants of the deadline-ordered event queue
// Request codes, result codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package doeq_pkg;

  // Default sizes
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
  localparam int unsigned DEFAULT_TIME_BITS   = 48;

  // Field widths
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned FIRE_WIN_W = 20;

  // Result tdata: due_handle, wake, occupancy, padded to bytes
  localparam int unsigned OUT_DATA_W = ((HANDLE_W + 1 + OCC_W + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = FIRE_WIN_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_FIRE_WIN = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_STOP     = CFG_ADDR_W'(1);

  localparam logic [FIRE_WIN_W-1:0] FIRE_WIN_RESET = FIRE_WIN_W'(1000);

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_SCHED_ABS = 2'd0,
    OP_SCHED_REL = 2'd1,
    OP_POLL      = 2'd2
  } op_e;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPTED = 3'd0,
    STATUS_STOPPED  = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_DUE      = 3'd3,
    STATUS_NONE     = 3'd4
  } status_e;

endpackage

>>> rtl/core/doeq_ram.sv
// ----------------------------------------------------------------------------
// doeq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module doeq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/deadline_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// deadline_ordered_event_queue: deadline-sorted store of event handles
// Schedule requests insert a handle in deadline order (ties: last in, first
// out); poll requests pop the head once it is within the firing window of now.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tuser: op; tdata: now, time, handle
//   m_axis    out  tvalid/tready             tuser: status; tdata: handle, wake, occ
//   cfg       in   cfg_we_i (no wait)        cfg_addr_i, cfg_wdata_i
//
// Entries live in one RAM as a circular buffer; head pointer and count are
// flops. A poll of a non-empty store passes S_POLL; a rejected, unknown or
// empty-store request goes straight to S_DONE. An absolute schedule passes
// S_FIRST, then walks from the tail in S_WALK (one RAM read-compare-write per
// cycle) and stores in S_PLACE; relative adds S_SCALE for the ms-to-us scaling
// and S_ADD for the saturating add. One request is in work at a time. Reset
// clears the control-state flops only; the RAM needs no clear.
// A new request is taken while a result still waits in the output register;
// the block stalls before handing over a result until that register frees.
// ----------------------------------------------------------------------------
module deadline_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = doeq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int unsigned TIME_BITS   = doeq_pkg::DEFAULT_TIME_BITS,
  localparam int unsigned InDataW    = ((2 * TIME_BITS + doeq_pkg::HANDLE_W + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // Request channel
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: now_us, time_value, event_handle (zero pad above)
  input  logic [InDataW-1:0]              s_axis_tdata,
  // tuser: op
  input  logic [doeq_pkg::OP_W-1:0]       s_axis_tuser,

  // Result channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: due_handle, wake, occupancy (zero pad above)
  output logic [doeq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status
  output logic [doeq_pkg::STATUS_W-1:0]   m_axis_tuser,

  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [doeq_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [doeq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import doeq_pkg::*;

  localparam int unsigned AddrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EntryW = TIME_BITS + HANDLE_W;
  localparam int unsigned ProdW  = TIME_BITS + 10;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned PadW   = OUT_DATA_W - (HANDLE_W + 1 + OCC_W);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_FIRST = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_PLACE = 8'b0010_0000,
    S_POLL  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  // Logical position to RAM address, relative to the head
  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                            input logic [AddrW-1:0] pos);
    logic [AddrW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (AddrW+1)'(QUEUE_DEPTH)) begin
      s = s - (AddrW+1)'(QUEUE_DEPTH);
    end
    return s[AddrW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [CntW-1:0]       count_q, count_d;
  logic [AddrW-1:0]      head_q, head_d;
  logic [AddrW-1:0]      slot_q, slot_d;
  logic [FIRE_WIN_W-1:0] fire_win_q;
  logic                  stop_q;

  // Request payload
  logic [TIME_BITS-1:0] now_q, tv_q, deadline_q, deadline_d;
  logic [HANDLE_W-1:0]  handle_q;
  logic [ProdW-1:0]     delay_q;

  // Pending result
  status_e             res_status_q, res_status_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic                res_wake_q, res_wake_d;

  // Output register
  logic                out_valid_q;
  status_e             out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic                out_wake_q;
  logic [OCC_W-1:0]    out_occ_q;

  logic                 in_fire, out_load;
  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0]    ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0] rd_deadline;
  logic [HANDLE_W-1:0]  rd_handle;
  logic [ProdW-1:0]     tv_ext;
  logic [SumW-1:0]      rel_sum;
  logic [TIME_BITS:0]   due_limit;
  op_e                  in_op;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign in_op    = op_e'(s_axis_tuser);

  assign rd_deadline = ram_rdata[TIME_BITS-1:0];
  assign rd_handle   = ram_rdata[EntryW-1:TIME_BITS];

  // 1000 = 1024 - 16 - 8
  assign tv_ext  = ProdW'(tv_q);
  assign rel_sum = SumW'(now_q) + SumW'(delay_q);

  // Head is due when deadline < now + window, without wrap
  assign due_limit = {1'b0, now_q} + (TIME_BITS+1)'(fire_win_q);

  // Entry store
  doeq_ram #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    slot_d       = slot_q;
    deadline_d   = deadline_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_wake_d   = res_wake_q;
    ram_we       = 1'b0;
    ram_waddr    = phys(head_q, slot_q);
    ram_wdata    = {handle_q, deadline_q};
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    case (state_q)
      S_IDLE: begin
        // Head read ahead for a poll
        ram_re = 1'b1;
        if (in_fire) begin
          res_status_d = STATUS_NONE;
          res_handle_d = '0;
          res_wake_d   = 1'b0;
          deadline_d   = s_axis_tdata[2*TIME_BITS-1:TIME_BITS];
          case (in_op)
            OP_SCHED_ABS, OP_SCHED_REL: begin
              if (stop_q) begin
                res_status_d = STATUS_STOPPED;
                state_d      = S_DONE;
              end else if (count_q == CntW'(QUEUE_DEPTH)) begin
                res_status_d = STATUS_FULL;
                state_d      = S_DONE;
              end else if (in_op == OP_SCHED_REL) begin
                state_d = S_SCALE;
              end else begin
                state_d = S_FIRST;
              end
            end
            OP_POLL: begin
              state_d = (count_q == '0) ? S_DONE : S_POLL;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCALE: begin
        state_d = S_ADD;
      end

      // Saturating now + delay
      S_ADD: begin
        if (rel_sum[SumW-1:TIME_BITS] != '0) begin
          deadline_d = '1;
        end else begin
          deadline_d = rel_sum[TIME_BITS-1:0];
        end
        state_d = S_FIRST;
      end

      // Start the walk at the tail
      S_FIRST: begin
        slot_d = count_q[AddrW-1:0];
        if (count_q == '0) begin
          state_d = S_PLACE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, count_q[AddrW-1:0] - AddrW'(1));
          state_d   = S_WALK;
        end
      end

      // Entry slot_q-1 is in rdata: move it up if not earlier than new
      S_WALK: begin
        if (rd_deadline >= deadline_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          slot_d    = slot_q - AddrW'(1);
          if (slot_q == AddrW'(1)) begin
            state_d = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_q, slot_q - AddrW'(2));
          end
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        ram_we       = 1'b1;
        count_d      = count_q + CntW'(1);
        res_status_d = STATUS_ACCEPTED;
        res_wake_d   = (slot_q == '0);
        state_d      = S_DONE;
      end

      // Head entry is in rdata
      S_POLL: begin
        if ({1'b0, rd_deadline} < due_limit) begin
          res_status_d = STATUS_DUE;
          res_handle_d = rd_handle;
          head_d       = phys(head_q, AddrW'(1));
          count_d      = count_q - CntW'(1);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      fire_win_q  <= FIRE_WIN_RESET;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_FIRE_WIN: fire_win_q <= cfg_wdata_i[FIRE_WIN_W-1:0];
          CFG_STOP:     stop_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    deadline_q   <= deadline_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_wake_q   <= res_wake_d;
    if (in_fire) begin
      now_q    <= s_axis_tdata[TIME_BITS-1:0];
      tv_q     <= s_axis_tdata[2*TIME_BITS-1:TIME_BITS];
      handle_q <= s_axis_tdata[2*TIME_BITS+HANDLE_W-1:2*TIME_BITS];
    end
    if (state_q == S_SCALE) begin
      delay_q <= (tv_ext << 10) - (tv_ext << 4) - (tv_ext << 3);
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_wake_q   <= res_wake_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_occ_q, out_wake_q, out_handle_q};

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CntW'(1) ||
              count_q == $past(count_q) - CntW'(1)))
    else $error("entry count moved by more than one");

  a_walk_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> slot_q != '0)
    else $error("insertion walk below the head");

  a_wake_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_wake_q |-> res_status_q == STATUS_ACCEPTED)
    else $error("wake flag on a result other than accepted");

endmodule
